// ===== sv/wcsa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the weighted capped share allocator.
// Holds widths, the sequencer state type and the divider request struct.
package wcsa_pkg;

	localparam int unsigned MAX_CLIENTS_DEF = 32;
	localparam int unsigned WSUM_W = 37;
	localparam int unsigned CNT_W = 7;
	localparam logic [16:0] FULL_SHARE = 17'd65536;
	localparam logic [CNT_W-1:0] RATIO_STEPS = 7'd64;
	localparam logic [CNT_W-1:0] FRAC_STEPS = 7'd17;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RSTART,
		S_RWAIT,
		S_FETCH,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_CMP,
		S_FWAIT,
		S_EREAD,
		S_EOUT,
		S_EWAIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [WSUM_W-1:0] rem_init;
		logic [63:0]       dividend;
		logic [WSUM_W-1:0] divisor;
		logic [CNT_W-1:0]  count;
	} div_req_t;

endpackage

// ===== sv/wcsa_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Depends on wcsa_pkg for the request struct and widths.
module wcsa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wcsa_pkg::div_req_t req,
	output logic              done,
	output logic [63:0]       quotient
);
	import wcsa_pkg::*;

	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WSUM_W-1:0] rem_q;
	logic [WSUM_W-1:0] dvs_q;
	logic [63:0]       dvd_q;
	logic [63:0]       quo_q;
	logic [WSUM_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[63]};
	assign fits = trial >= {1'b0, dvs_q};
	assign done = run_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= req.count;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (run_q && (cnt_q != '0)) begin
			rem_q <= fits ? WSUM_W'(trial - {1'b0, dvs_q}) : trial[WSUM_W-1:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], fits};
		end
	end

endmodule

// ===== sv/wcsa_mul.sv =====
`timescale 1ns / 1ps
// Shared 32 by 32 bit multiplier with a registered product.
// No package dependencies.
module wcsa_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] product
);
	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign product = prod_q;

endmodule

// ===== sv/weighted_capped_share_allocator_core.sv =====
`timescale 1ns / 1ps
// Top level of the weighted capped share allocator: stores, sequencer, output register.
// Depends on wcsa_pkg, wcsa_div and wcsa_mul.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   weight, demand, supply, final_client
// out       output     out_valid/out_ready client_index, granted_fraction, final_result
//
// A non-final beat is stored and the loader stays ready. A final beat starts passes over
// the set: each pass gets the ratio from the shared divider unless no weight is left, then
// per client multiplies, checks the cap and divides; a capped client restarts the pass.
// Results pass S_EREAD, S_EOUT, S_EWAIT and any out_ready stall; no beat is taken meanwhile.
// Reset clears the sequencer and counters; the stores need no clearing.
module weighted_capped_share_allocator_core #(
	parameter int unsigned MAX_CLIENTS = wcsa_pkg::MAX_CLIENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] weight,
	input  logic [31:0] demand,
	input  logic [31:0] supply,
	input  logic        final_client,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  client_index,
	output logic [16:0] granted_fraction,
	output logic        final_result
);
	import wcsa_pkg::*;

	localparam int unsigned IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_CLIENTS + 1);

	state_t state_q, state_d;

	logic [31:0] weight_mem [MAX_CLIENTS];
	logic [31:0] demand_mem [MAX_CLIENTS];
	logic [16:0] frac_mem [MAX_CLIENTS];

	logic [CW-1:0]     cnt_q, n_q, i_q;
	logic [WSUM_W-1:0] wsum_q, rw_q;
	logic [31:0]       supply_q;
	logic [63:0]       ratio_q;
	logic [31:0]       rd_w_q, rd_d_q;
	logic [16:0]       rd_f_q;
	logic [63:0]       lo_q, p_lo_q;
	logic              p_hi_nz_q;
	logic [MAX_CLIENTS-1:0] full_q;
	logic [4:0]        idx_out_q;
	logic [16:0]       frac_out_q;
	logic              last_out_q;

	logic [IW-1:0]     ix;
	logic              take, store_it, rd_en, cap, last_i;
	logic [31:0]       mul_a;
	logic [63:0]       mul_p;
	logic [64:0]       lo_sum;
	logic [IW+4:0]     ix_ext;
	div_req_t          dreq;
	logic              div_done;
	logic [63:0]       div_q;

	assign ix = i_q[IW-1:0];
	assign ix_ext = {5'b0, ix};
	assign take = in_valid && in_ready;
	assign store_it = cnt_q < CW'(MAX_CLIENTS);
	assign cap = (rd_d_q != '0) && (p_hi_nz_q || (p_lo_q > {rd_d_q, 32'b0}));
	assign last_i = (i_q + CW'(1)) == n_q;
	assign lo_sum = {1'b0, lo_q} + {1'b0, mul_p[31:0], 32'b0};

	assign out_valid = (state_q == S_EWAIT);
	assign client_index = idx_out_q;
	assign granted_fraction = frac_out_q;
	assign final_result = last_out_q;

	wcsa_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(rd_w_q),
		.product(mul_p)
	);

	wcsa_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.done(div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		rd_en = 1'b0;
		mul_a = ratio_q[31:0];
		dreq = '0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (take && final_client) begin
					state_d = S_RSTART;
				end
			end
			S_RSTART: begin
				if (rw_q == '0) begin
					state_d = S_FETCH;
				end else begin
					dreq.start = 1'b1;
					dreq.rem_init = '0;
					dreq.dividend = {supply_q, 32'b0};
					dreq.divisor = rw_q;
					dreq.count = RATIO_STEPS;
					state_d = S_RWAIT;
				end
			end
			S_RWAIT: begin
				if (div_done) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				if (i_q == n_q) begin
					state_d = S_EREAD;
				end else if (!full_q[ix]) begin
					rd_en = 1'b1;
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: begin
				mul_a = ratio_q[31:0];
				state_d = S_MUL_HI;
			end
			S_MUL_HI: begin
				mul_a = ratio_q[63:32];
				state_d = S_SUM;
			end
			S_SUM: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (cap) begin
					state_d = S_RSTART;
				end else if (rd_d_q != '0) begin
					dreq.start = 1'b1;
					dreq.rem_init = WSUM_W'(p_lo_q[63:33]);
					dreq.dividend = {p_lo_q[32:16], 47'b0};
					dreq.divisor = WSUM_W'(rd_d_q);
					dreq.count = FRAC_STEPS;
					state_d = S_FWAIT;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_FWAIT: begin
				if (div_done) begin
					state_d = S_FETCH;
				end
			end
			S_EREAD: begin
				rd_en = 1'b1;
				state_d = S_EOUT;
			end
			S_EOUT: begin
				state_d = S_EWAIT;
			end
			S_EWAIT: begin
				if (out_ready) begin
					state_d = last_out_q ? S_LOAD : S_EREAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			wsum_q <= '0;
			rw_q <= '0;
			supply_q <= '0;
			ratio_q <= '0;
			full_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (take) begin
						if (final_client) begin
							supply_q <= supply;
							full_q <= '0;
							cnt_q <= '0;
							wsum_q <= '0;
							n_q <= store_it ? CW'(cnt_q + 1'b1) : cnt_q;
							rw_q <= store_it ? WSUM_W'(wsum_q + WSUM_W'(weight)) : wsum_q;
						end else if (store_it) begin
							cnt_q <= cnt_q + 1'b1;
							wsum_q <= WSUM_W'(wsum_q + WSUM_W'(weight));
						end
					end
				end
				S_RSTART: begin
					i_q <= '0;
					ratio_q <= '0;
				end
				S_RWAIT: begin
					if (div_done) begin
						ratio_q <= div_q;
					end
				end
				S_FETCH: begin
					if (i_q == n_q) begin
						i_q <= '0;
					end else if (full_q[ix]) begin
						i_q <= i_q + 1'b1;
					end
				end
				S_CMP: begin
					if (cap) begin
						full_q[ix] <= 1'b1;
						supply_q <= (supply_q > rd_d_q) ? supply_q - rd_d_q : '0;
						rw_q <= (rw_q > WSUM_W'(rd_w_q)) ? rw_q - WSUM_W'(rd_w_q) : '0;
					end else if (rd_d_q == '0) begin
						i_q <= i_q + 1'b1;
					end
				end
				S_FWAIT: begin
					if (div_done) begin
						i_q <= i_q + 1'b1;
						if (div_q[16:0] == FULL_SHARE) begin
							full_q[ix] <= 1'b1;
						end
					end
				end
				S_EWAIT: begin
					if (out_ready) begin
						i_q <= last_out_q ? '0 : i_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && store_it) begin
			weight_mem[cnt_q[IW-1:0]] <= weight;
			demand_mem[cnt_q[IW-1:0]] <= demand;
		end
		if ((state_q == S_CMP) && !cap && (rd_d_q == '0)) begin
			frac_mem[ix] <= '0;
		end else if ((state_q == S_FWAIT) && div_done) begin
			frac_mem[ix] <= div_q[16:0];
		end
		if (rd_en) begin
			rd_w_q <= weight_mem[ix];
			rd_d_q <= demand_mem[ix];
			rd_f_q <= frac_mem[ix];
		end
		if (state_q == S_MUL_HI) begin
			lo_q <= mul_p;
		end
		if (state_q == S_SUM) begin
			p_lo_q <= lo_sum[63:0];
			p_hi_nz_q <= (mul_p[63:32] != '0) || lo_sum[64];
		end
		if (state_q == S_EOUT) begin
			idx_out_q <= ix_ext[4:0];
			frac_out_q <= full_q[ix] ? FULL_SHARE : rd_f_q;
			last_out_q <= last_i;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("Input taken while a result is pending.");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FWAIT && div_done) |-> (div_q[63:0] <= 64'(FULL_SHARE)))
		else $error("Satisfied fraction exceeds a full share.");

	a_final_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_client) |=> (state_q == S_RSTART))
		else $error("Final beat did not start allocation.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CW'(MAX_CLIENTS)) && (n_q <= CW'(MAX_CLIENTS)))
		else $error("Client count beyond capacity.");

endmodule

// ===== test/weighted_capped_share_allocator_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for weighted_capped_share_allocator_core: a directed table, then random client sets,
// checked against a fixed-point water-filling predictor or a row's expected fraction. Depends on the RTL only.
module weighted_capped_share_allocator_core_test;

	localparam int NCLIENT = 32;
	localparam int NRANDOM = 250;
	localparam int QUIET_AFTER = 220;
	localparam int LIMIT = 3000000;
	localparam int LONG_HOLD = 2000;
	localparam logic [16:0] FULL = 17'd65536;

	typedef struct {
		logic [4:0]  idx;
		logic [16:0] frac;
		logic        last;
	} share_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] weight = '0;
	logic [31:0] demand = '0;
	logic [31:0] supply = '0;
	logic        final_client = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  client_index;
	logic [16:0] granted_fraction;
	logic        final_result;

	share_t      granted_q[$];
	logic [31:0] weight_mem[NCLIENT];
	logic [31:0] demand_mem[NCLIENT];
	int          loaded = 0;
	int          errors = 0;
	int          cycles = 0;
	int          sent = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;

	logic [31:0] row_w[$], row_d[$], row_s[$];
	bit          row_f[$], row_chk[$];
	logic [16:0] row_exp[$];

	weighted_capped_share_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.weight(weight), .demand(demand), .supply(supply), .final_client(final_client),
		.out_valid(out_valid), .out_ready(out_ready),
		.client_index(client_index), .granted_fraction(granted_fraction),
		.final_result(final_result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[weighted_capped_share_allocator_core] ERROR");
			$finish;
		end
	end

	task automatic share_out(input logic [31:0] sup, input bit chk, input logic [16:0] exp_frac);
		logic [16:0] frac[NCLIENT];
		logic [31:0] rsup;
		logic [36:0] rwt;
		logic [63:0] ratio;
		logic [95:0] prod;
		logic [63:0] q;
		logic [31:0] w, d;
		bit          restart;
		int          i;
		share_t      r;
		rsup = sup;
		rwt = '0;
		for (i = 0; i < loaded; i++) begin
			rwt += {5'b0, weight_mem[i]};
			frac[i] = '0;
		end
		restart = 1'b1;
		while (restart) begin
			restart = 1'b0;
			ratio = (rwt != 0) ? {rsup, 32'b0} / {27'b0, rwt} : 64'd0;
			for (i = 0; i < loaded && !restart; i++) begin
				if (frac[i] != FULL) begin
					w = weight_mem[i];
					d = demand_mem[i];
					prod = {32'b0, ratio} * {64'b0, w};
					if (d != 0 && prod > {32'b0, d, 32'b0}) begin
						frac[i] = FULL;
						rsup = (rsup > d) ? rsup - d : 32'd0;
						rwt = (rwt > {5'b0, w}) ? rwt - {5'b0, w} : 37'd0;
						restart = 1'b1;
					end else if (d != 0) begin
						q = prod[63:0] / {16'b0, d, 16'b0};
						frac[i] = (q > 64'd65536) ? FULL : q[16:0];
					end else begin
						frac[i] = '0;
					end
				end
			end
		end
		for (i = 0; i < loaded; i++) begin
			r.idx = i[4:0];
			r.frac = chk ? exp_frac : frac[i];
			r.last = (i + 1 == loaded);
			granted_q.push_back(r);
		end
		loaded = 0;
	endtask

	task automatic load_client(input logic [31:0] w, d, s, input bit f, chk,
			input logic [16:0] exp_frac);
		if (loaded < NCLIENT) begin
			weight_mem[loaded] = w;
			demand_mem[loaded] = d;
			loaded++;
		end
		if (f)
			share_out(s, chk, exp_frac);
	endtask

	task automatic send_beat(input logic [31:0] w, d, s, input bit f, chk,
			input logic [16:0] exp_frac);
		int gap;
		in_valid <= 1'b1;
		weight <= w;
		demand <= d;
		supply <= s;
		final_client <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		load_client(w, d, s, f, chk, exp_frac);
		sent++;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [31:0] w, d, s, input bit f, chk,
			input logic [16:0] exp_frac);
		row_w.push_back(w);
		row_d.push_back(d);
		row_s.push_back(s);
		row_f.push_back(f);
		row_chk.push_back(chk);
		row_exp.push_back(exp_frac);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: pick_value = 32'd0;
			1: pick_value = 32'hFFFF_FFFF;
			2: pick_value = $urandom_range(1, 16);
			3: pick_value = $urandom_range(1, 256) << 16;
			default: pick_value = $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		share_t e;
		if (out_valid && out_ready) begin
			if (granted_q.size() == 0) begin
				$error("unexpected result beat, client_index %0d", client_index);
				errors++;
			end else begin
				e = granted_q.pop_front();
				if (client_index !== e.idx) begin
					$error("client_index expected %0d actual %0d", e.idx, client_index);
					errors++;
				end
				if (granted_fraction !== e.frac) begin
					$error("granted_fraction expected %0d actual %0d", e.frac,
						granted_fraction);
					errors++;
				end
				if (final_result !== e.last) begin
					$error("final_result expected %0d actual %0d", e.last, final_result);
					errors++;
				end
			end
		end
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		int i, n, k, set_no;
		logic [31:0] s;
		add_row(32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 17'd0);
		add_row(32'd0, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1, 17'd0);
		add_row(32'd1, 32'h0001_0000, 32'h0002_0000, 1'b1, 1'b1, FULL);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, FULL);
		add_row(32'd1, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b1, 17'd32768);
		add_row(32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 17'd0);
		add_row(32'd3, 32'h0001_0000, 32'hDEAD_BEEF, 1'b0, 1'b0, 17'd0);
		add_row(32'd1, 32'h0100_0000, 32'h1234_5678, 1'b0, 1'b0, 17'd0);
		add_row(32'd2, 32'd0, 32'h0, 1'b0, 1'b0, 17'd0);
		add_row(32'd2, 32'h0003_0000, 32'h0008_0000, 1'b1, 1'b0, 17'd0);
		add_row(32'hFFFF_FFFF, 32'h0000_0001, 32'd0, 1'b0, 1'b0, 17'd0);
		add_row(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0);
		add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 1'b1, 1'b0, 17'd0);
		add_row(32'd5, 32'h0002_0000, 32'd0, 1'b0, 1'b0, 17'd0);
		add_row(32'd7, 32'h0004_0000, 32'd0, 1'b1, 1'b0, 17'd0);
		add_row(32'd1, 32'h0000_8000, 32'hAAAA_AAAA, 1'b0, 1'b0, 17'd0);
		add_row(32'd1, 32'h0000_8000, 32'h0, 1'b0, 1'b0, 17'd0);
		add_row(32'd1, 32'h0000_8000, 32'h0, 1'b0, 1'b0, 17'd0);
		add_row(32'd1, 32'h0010_0000, 32'h0002_0000, 1'b1, 1'b0, 17'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < row_w.size(); i++)
			send_beat(row_w[i], row_d[i], row_s[i], row_f[i], row_chk[i], row_exp[i]);

		hold_req = 1'b1;
		sent = 0;
		set_no = 0;
		while (sent < NRANDOM) begin
			k = $urandom_range(0, 19);
			if (set_no == 5)
				n = 34;
			else if (k == 0)
				n = 32;
			else if (k == 1)
				n = $urandom_range(9, 31);
			else
				n = $urandom_range(1, 8);
			if (set_no == 8) begin
				in_valid <= 1'b0;
				while (granted_q.size() != 0)
					@(posedge clk);
			end
			for (i = 0; i < n; i++) begin
				s = (i == n - 1) ? pick_value() : $urandom;
				quiet = (sent >= QUIET_AFTER);
				send_beat(pick_value(), pick_value(), s, i == n - 1, 1'b0, 17'd0);
			end
			set_no++;
		end
		in_valid <= 1'b0;
		final_client <= 1'b0;
		while (granted_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[weighted_capped_share_allocator_core] OK");
		else
			$display("[weighted_capped_share_allocator_core] ERROR");
		$finish;
	end

endmodule
